// File: rtl/ptjlg_pkg.sv
`default_nettype none

package ptjlg_pkg;

	localparam int unsigned ANGLE_WIDTH_DEF = 16;
	localparam int unsigned SPEED_W         = 16;
	localparam int unsigned LIMIT_W         = 15;
	localparam int unsigned CFG_IDX_W       = 2;

	localparam logic [LIMIT_W-1:0] PAN_LIMIT_RST  = 15'd32767;
	localparam logic [LIMIT_W-1:0] TILT_LIMIT_RST = 15'd32767;
	localparam logic [LIMIT_W-1:0] MARGIN_RST     = 15'd143;

	localparam logic [CFG_IDX_W-1:0] REG_PAN_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 2'd2;

	typedef logic signed [SPEED_W-1:0] speed_t;

	typedef struct packed {
		speed_t cmd;
		speed_t last;
		logic   halted;
		logic   armed;
	} axis_state_t;

	typedef struct packed {
		axis_state_t nxt;
		logic        send;
		logic        moving;
	} axis_result_t;

	// Halt and limit-arming rules of one axis for one tick.
	function automatic axis_result_t axis_step(input axis_state_t cur, input speed_t req,
			input logic in_limit);
		axis_result_t r;
		logic fresh;
		logic rev;
		logic req_pos;
		logic req_neg;
		logic last_pos;
		logic last_neg;
		logic stop;
		r        = '0;
		r.nxt    = cur;
		fresh    = (req != cur.last);
		req_neg  = req[SPEED_W-1];
		req_pos  = !req[SPEED_W-1] && (req != '0);
		last_neg = cur.last[SPEED_W-1];
		last_pos = !cur.last[SPEED_W-1] && (cur.last != '0);
		rev      = (req_pos && last_neg) || (req_neg && last_pos);
		stop     = in_limit;
		if (fresh) begin
			if (in_limit) begin
				if (!rev) begin
					if (cur.armed) begin
						if (!cur.halted) begin
							r.nxt.cmd    = '0;
							r.nxt.halted = 1'b1;
							r.send       = 1'b1;
						end
					end else begin
						r.nxt.cmd    = req;
						stop         = 1'b0;
						r.nxt.halted = 1'b0;
						r.send       = 1'b1;
					end
				end else begin
					if (cur.armed) begin
						r.nxt.cmd    = req;
						stop         = 1'b0;
						r.nxt.halted = 1'b0;
						r.nxt.armed  = 1'b0;
						r.send       = 1'b1;
					end else if (!cur.halted) begin
						r.nxt.cmd    = '0;
						r.nxt.halted = 1'b1;
						r.nxt.armed  = 1'b1;
						r.send       = 1'b1;
					end
				end
			end else begin
				r.nxt.cmd   = req;
				r.nxt.armed = 1'b1;
				r.send      = 1'b1;
			end
		end else begin
			if (in_limit) begin
				if (cur.armed && !cur.halted) begin
					r.nxt.cmd    = '0;
					r.nxt.halted = 1'b1;
					r.send       = 1'b1;
				end
			end else begin
				r.nxt.armed = 1'b1;
			end
		end
		r.nxt.last = req;
		r.moving   = !stop;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/pan_tilt_joint_limit_guard.sv
`default_nettype none

// Pan/tilt joint limit guard. Each input transaction is one control tick: the
// measured pan and tilt angles (signed Q3.12 rad, ANGLE_WIDTH bits) and the
// requested speeds (signed Q3.12 rad/s). For each axis the angle is checked
// against the soft limit (joint limit minus margin, used as is even when it
// goes negative), and the halt and re-arm rules decide the held speed command.
// Every tick yields exactly one output transaction with both held commands,
// send_cmd (some command was rewritten this tick), the limit flags and the
// moving status. One transaction is accepted per clock: the item is held in an
// input register, the rules are evaluated there against the axis state, and
// the result lands in the output register, so throughput is one tick per cycle
// while out_stall is low. in_stall follows out_stall only when both registers
// are full. Write the limit registers only while no tick is in flight. Reset:
// commands and last requests zero, axes un-halted and armed, limits 32767,
// margin 143.
module pan_tilt_joint_limit_guard
	import ptjlg_pkg::*;
#(
	parameter int unsigned ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [LIMIT_W-1:0]            cfg_data,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [ANGLE_WIDTH-1:0] pan_angle,
	input  wire logic signed [ANGLE_WIDTH-1:0] tilt_angle,
	input  wire logic signed [SPEED_W-1:0]     desired_pan,
	input  wire logic signed [SPEED_W-1:0]     desired_tilt,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [SPEED_W-1:0]          cmd_pan,
	output logic signed [SPEED_W-1:0]          cmd_tilt,
	output logic                               send_cmd,
	output logic                               limit_pan,
	output logic                               limit_tilt,
	output logic                               moving_pan,
	output logic                               moving_tilt
);

	// Compare width: wide enough for the angle, the soft limit and its negation.
	localparam int unsigned CMP_W = ((ANGLE_WIDTH > LIMIT_W + 1) ? ANGLE_WIDTH : LIMIT_W + 1) + 1;

	// configuration registers
	logic [LIMIT_W-1:0] pan_limit_q;
	logic [LIMIT_W-1:0] tilt_limit_q;
	logic [LIMIT_W-1:0] margin_q;

	// input register
	logic                          valid_s1;
	logic signed [ANGLE_WIDTH-1:0] pan_angle_s1;
	logic signed [ANGLE_WIDTH-1:0] tilt_angle_s1;
	speed_t                        desired_pan_s1;
	speed_t                        desired_tilt_s1;

	// axis state
	axis_state_t pan_q;
	axis_state_t tilt_q;

	logic advance;

	logic signed [CMP_W-1:0] pan_soft;
	logic signed [CMP_W-1:0] tilt_soft;
	logic signed [CMP_W-1:0] pan_ang_x;
	logic signed [CMP_W-1:0] tilt_ang_x;
	logic                    pan_in_limit;
	logic                    tilt_in_limit;
	axis_result_t            pan_res;
	axis_result_t            tilt_res;

	// The output register moves when it is empty or being drained; the input
	// register moves into it on the same condition.
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_limit_q  <= PAN_LIMIT_RST;
			tilt_limit_q <= TILT_LIMIT_RST;
			margin_q     <= MARGIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAN_LIMIT:  pan_limit_q  <= cfg_data;
				REG_TILT_LIMIT: tilt_limit_q <= cfg_data;
				REG_MARGIN:     margin_q     <= cfg_data;
				default: ;  // unknown index: drop the write
			endcase
		end
	end

	// Soft limits may go negative; then every angle counts as in limit.
	always_comb begin
		pan_soft      = signed'(CMP_W'({1'b0, pan_limit_q})) - signed'(CMP_W'({1'b0, margin_q}));
		tilt_soft     = signed'(CMP_W'({1'b0, tilt_limit_q})) - signed'(CMP_W'({1'b0, margin_q}));
		pan_ang_x     = CMP_W'(pan_angle_s1);
		tilt_ang_x    = CMP_W'(tilt_angle_s1);
		pan_in_limit  = (pan_ang_x < -pan_soft) || (pan_ang_x > pan_soft);
		tilt_in_limit = (tilt_ang_x < -tilt_soft) || (tilt_ang_x > tilt_soft);
		pan_res       = axis_step(pan_q, desired_pan_s1, pan_in_limit);
		tilt_res      = axis_step(tilt_q, desired_tilt_s1, tilt_in_limit);
	end

	// Input register: hold while stalled, load on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pan_angle_s1    <= pan_angle;
			tilt_angle_s1   <= tilt_angle;
			desired_pan_s1  <= desired_pan;
			desired_tilt_s1 <= desired_tilt;
		end
	end

	// Axis state advances exactly once per tick, when the tick moves to output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_q  <= '{cmd: '0, last: '0, halted: 1'b0, armed: 1'b1};
			tilt_q <= '{cmd: '0, last: '0, halted: 1'b0, armed: 1'b1};
		end else if (valid_s1 && advance) begin
			pan_q  <= pan_res.nxt;
			tilt_q <= tilt_res.nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			cmd_pan     <= pan_res.nxt.cmd;
			cmd_tilt    <= tilt_res.nxt.cmd;
			send_cmd    <= pan_res.send || tilt_res.send;
			limit_pan   <= pan_in_limit;
			limit_tilt  <= tilt_in_limit;
			moving_pan  <= pan_res.moving;
			moving_tilt <= tilt_res.moving;
		end
	end

endmodule

`default_nettype wire
